// ----- design/thaq_pkg.sv -----
package thaq_pkg;

  localparam int SlotW   = 6;
  localparam int SampleW = 16;
  localparam int DelayW  = 16;
  localparam int TimeW   = 32;
  localparam int InDataW = 128;
  localparam int OutDataW = 16;

  typedef enum logic [1:0] {
    PRE_NONE    = 2'd0,
    PRE_IDLE    = 2'd1,
    PRE_RUNNING = 2'd2,
    PRE_FAULTED = 2'd3
  } pre_t;

  typedef enum logic [1:0] {
    KIND_UPPER = 2'd0,
    KIND_LOWER = 2'd1,
    KIND_FLAG  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    LVL_BAND    = 2'd0,
    LVL_ASSERT  = 2'd1,
    LVL_RELEASE = 2'd2
  } lvl_t;

  typedef enum logic [1:0] {
    TR_NONE    = 2'd0,
    TR_RAISED  = 2'd1,
    TR_CLEARED = 2'd2
  } trans_t;

  typedef enum logic {
    BK_READ = 1'b0,
    BK_EXEC = 1'b1
  } bk_state_t;

  // Classified evaluation waiting for the slot update.
  typedef struct packed {
    logic [SlotW-1:0]  slot;
    pre_t              pre;
    logic              latching;
    lvl_t              level;
    logic [DelayW-1:0] set_delay;
    logic [DelayW-1:0] clear_delay;
    logic [TimeW-1:0]  now_ms;
  } entry_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             active;
    trans_t           transition;
    lvl_t             level;
  } result_t;

endpackage

// ----- design/timed_hysteresis_alarm_qualifier.sv -----
// A transaction passes the input queue, then the read state and the update
// state of the slot state memory; the result is registered at the update.
// The back end handles one transaction at a time, read and then update; a
// two-entry queue lets the input keep accepting while a result waits at the output.
// Reset: synchronous, clears the queue, the output and per-slot written marks,
// so every slot reads as inactive with a zero stamp; no clearing pass is needed.
module timed_hysteresis_alarm_qualifier #(
  parameter int ALARM_SLOTS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // alarm_index, sample, precondition, latching, limit, hysteresis,
  // set_delay, clear_delay, now_ms, zero fill
  input  logic [thaq_pkg::InDataW-1:0]   s_tdata,
  // check_kind
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // slot, active, transition, level_class, zero fill
  output logic [thaq_pkg::OutDataW-1:0]  m_tdata
);
  import thaq_pkg::*;

  logic    q_full;
  logic    q_push;
  logic    q_pop;
  logic    q_not_empty;
  entry_t  q_entry;
  entry_t  q_head;
  result_t out_result;

  thaq_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  thaq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  thaq_back #(
    .ALARM_SLOTS (ALARM_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_result  (out_result)
  );

  assign m_tdata = {5'b0, out_result.level, out_result.transition,
                    out_result.active, out_result.slot};

endmodule

// ----- design/thaq_front.sv -----
module thaq_front (
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [thaq_pkg::InDataW-1:0]  s_tdata,
  input  logic [1:0]                    s_tuser,
  input  logic                          q_full,
  output logic                          q_push,
  output thaq_pkg::entry_t              q_entry
);
  import thaq_pkg::*;

  logic [SampleW-1:0] sample;
  logic [SampleW-1:0] limit;
  logic [SampleW-1:0] hyst;
  logic [SampleW-1:0] rel_upper;
  logic [SampleW:0]   rel_lower;
  lvl_t               level;

  assign sample = s_tdata[21:6];
  assign limit  = s_tdata[40:25];
  assign hyst   = s_tdata[56:41];

  // Upper-limit release point is clamped at zero; the lower-limit one is kept
  // at 17 bits so that an overflowing sum can never be reached.
  assign rel_upper = (limit > hyst) ? (limit - hyst) : '0;
  assign rel_lower = {1'b0, limit} + {1'b0, hyst};

  always_comb begin
    level = LVL_BAND;
    case (kind_t'(s_tuser))
      KIND_UPPER: begin
        if (sample >= limit) level = LVL_ASSERT;
        else if (sample <= rel_upper) level = LVL_RELEASE;
      end
      KIND_LOWER: begin
        if (sample <= limit) level = LVL_ASSERT;
        else if ({1'b0, sample} >= rel_lower) level = LVL_RELEASE;
      end
      KIND_FLAG: begin
        level = (sample != '0) ? LVL_ASSERT : LVL_RELEASE;
      end
      default: level = LVL_BAND;
    endcase
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_entry.slot        = s_tdata[5:0];
    q_entry.pre         = pre_t'(s_tdata[23:22]);
    q_entry.latching    = s_tdata[24];
    q_entry.level       = level;
    q_entry.set_delay   = s_tdata[72:57];
    q_entry.clear_delay = s_tdata[88:73];
    q_entry.now_ms      = s_tdata[120:89];
  end

endmodule

// ----- design/thaq_queue.sv -----
module thaq_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  thaq_pkg::entry_t  push_entry,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output thaq_pkg::entry_t  head
);
  import thaq_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/thaq_back.sv -----
module thaq_back #(
  parameter int ALARM_SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  thaq_pkg::entry_t  q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output thaq_pkg::result_t out_result
);
  import thaq_pkg::*;

  localparam int SlotAw = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int ExtW   = 9;

  // Each word holds the active flag above the 32-bit qualification stamp.
  logic [TimeW:0]         mem [ALARM_SLOTS];
  logic [ALARM_SLOTS-1:0] written;

  bk_state_t         state;
  bk_state_t         state_next;
  logic [ExtW-1:0]   slot_ext;
  logic [SlotAw-1:0] addr;
  logic              in_range;
  logic              rd_en;
  logic              fire;
  logic              rd_written;
  logic [TimeW:0]    rd_word;
  logic              cur_act;
  logic [TimeW-1:0]  cur_stamp;
  logic [TimeW-1:0]  elapsed;
  logic              restart;
  logic              new_act;
  trans_t            trans;
  logic [TimeW-1:0]  new_stamp;
  result_t           res;

  assign slot_ext = {{(ExtW-SlotW){1'b0}}, q_head.slot};
  assign addr     = slot_ext[SlotAw-1:0];
  assign in_range = slot_ext < ExtW'(ALARM_SLOTS);

  always_comb begin
    state_next = state;
    case (state)
      BK_READ: if (q_not_empty) state_next = BK_EXEC;
      BK_EXEC: if (fire) state_next = BK_READ;
      default: state_next = BK_READ;
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    fire  = 1'b0;
    case (state)
      BK_READ: rd_en = q_not_empty;
      BK_EXEC: fire  = !out_valid || out_ready;
      default: begin
        rd_en = 1'b0;
        fire  = 1'b0;
      end
    endcase
  end

  assign q_pop = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_READ;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word    <= mem[addr];
      rd_written <= written[addr];
    end
  end

  // Slots never written since reset read as inactive with a zero stamp.
  assign cur_act   = rd_written && rd_word[TimeW];
  assign cur_stamp = rd_written ? rd_word[TimeW-1:0] : '0;
  assign elapsed   = q_head.now_ms - cur_stamp;

  always_comb begin
    restart = 1'b1;
    new_act = cur_act;
    trans   = TR_NONE;
    if (cur_act) begin
      if (q_head.pre == PRE_NONE || q_head.pre == PRE_FAULTED) begin
        if (!q_head.latching && q_head.level == LVL_RELEASE) begin
          if (elapsed > {{(TimeW-DelayW){1'b0}}, q_head.clear_delay}) begin
            new_act = 1'b0;
            trans   = TR_CLEARED;
          end else begin
            restart = 1'b0;
          end
        end
      end else if (q_head.pre == PRE_IDLE) begin
        new_act = 1'b0;
        trans   = TR_CLEARED;
      end
    end else if (q_head.pre == PRE_NONE || q_head.pre == PRE_RUNNING) begin
      if (q_head.level == LVL_ASSERT) begin
        if (elapsed > {{(TimeW-DelayW){1'b0}}, q_head.set_delay}) begin
          new_act = 1'b1;
          trans   = TR_RAISED;
        end else begin
          restart = 1'b0;
        end
      end
    end
    new_stamp = restart ? q_head.now_ms : cur_stamp;
  end

  always_comb begin
    res.slot       = q_head.slot;
    res.level      = q_head.level;
    res.active     = in_range ? new_act : 1'b0;
    res.transition = in_range ? trans : TR_NONE;
  end

  always_ff @(posedge clk) begin
    if (fire && in_range) begin
      mem[addr] <= {new_act, new_stamp};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (fire && in_range) begin
      written[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= res;
    end
  end

endmodule

// ----- tb/timed_hysteresis_alarm_qualifier_checker.sv -----
module timed_hysteresis_alarm_qualifier_checker #(
  parameter int SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [thaq_pkg::InDataW-1:0]  s_tdata,
  input  logic [1:0]                    s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [thaq_pkg::OutDataW-1:0] m_tdata,
  output int                            fail_count,
  output int                            pending,
  output int                            result_count,
  output int                            raise_count,
  output int                            clear_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import thaq_pkg::*;

  logic        slot_active [SLOTS];
  logic [31:0] slot_stamp  [SLOTS];
  result_t     alarm_q[$];

  function automatic lvl_t classify_level(logic [1:0] kind, logic [15:0] sample,
                                          logic [15:0] limit, logic [15:0] hyst);
    logic [15:0] release_at;
    logic [16:0] lower_release;
    classify_level = LVL_BAND;
    case (kind)
      KIND_UPPER: begin
        release_at = (limit > hyst) ? limit - hyst : 16'd0;
        if (sample >= limit) classify_level = LVL_ASSERT;
        else if (sample <= release_at) classify_level = LVL_RELEASE;
      end
      KIND_LOWER: begin
        // A release point past the sample range can never be reached.
        lower_release = {1'b0, limit} + {1'b0, hyst};
        if (sample <= limit) classify_level = LVL_ASSERT;
        else if ({1'b0, sample} >= lower_release) classify_level = LVL_RELEASE;
      end
      KIND_FLAG: classify_level = (sample != 16'd0) ? LVL_ASSERT : LVL_RELEASE;
      default: classify_level = LVL_BAND;
    endcase
  endfunction

  // Fields of s_tdata from bit 0: alarm_index, sample, precondition, latching,
  // limit, hysteresis, set_delay, clear_delay, now_ms.
  function automatic result_t evaluate_alarm(logic [127:0] data, logic [1:0] kind);
    logic [5:0]  slot;
    logic [15:0] sample, limit, hyst, set_delay, clear_delay;
    pre_t        pre;
    logic        latching, restart;
    logic [31:0] now, elapsed;
    result_t     res;
    slot        = data[5:0];
    sample      = data[21:6];
    pre         = pre_t'(data[23:22]);
    latching    = data[24];
    limit       = data[40:25];
    hyst        = data[56:41];
    set_delay   = data[72:57];
    clear_delay = data[88:73];
    now         = data[120:89];
    res.slot       = slot;
    res.level      = classify_level(kind, sample, limit, hyst);
    res.transition = TR_NONE;
    res.active     = 1'b0;
    if (slot < SLOTS) begin
      elapsed = now - slot_stamp[slot];
      restart = 1'b1;
      if (slot_active[slot]) begin
        if (pre == PRE_NONE || pre == PRE_FAULTED) begin
          if (!latching && res.level == LVL_RELEASE) begin
            if (elapsed > 32'(clear_delay)) begin
              slot_active[slot] = 1'b0;
              res.transition = TR_CLEARED;
            end else begin
              restart = 1'b0;
            end
          end
        end else if (pre == PRE_IDLE) begin
          slot_active[slot] = 1'b0;
          res.transition = TR_CLEARED;
        end
      end else if (pre == PRE_NONE || pre == PRE_RUNNING) begin
        if (res.level == LVL_ASSERT) begin
          if (elapsed > 32'(set_delay)) begin
            slot_active[slot] = 1'b1;
            res.transition = TR_RAISED;
          end else begin
            restart = 1'b0;
          end
        end
      end
      if (restart) slot_stamp[slot] = now;
      res.active = slot_active[slot];
    end
    if (res.transition == TR_RAISED) raise_count++;
    if (res.transition == TR_CLEARED) clear_count++;
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want, got;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_active[i] = 1'b0;
        slot_stamp[i]  = '0;
      end
      alarm_q.delete();
    end else begin
      if (s_tvalid && s_tready) alarm_q.push_back(evaluate_alarm(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        // Fields of m_tdata from bit 0: slot, active, transition, level_class.
        got.slot       = m_tdata[5:0];
        got.active     = m_tdata[6];
        got.transition = trans_t'(m_tdata[8:7]);
        got.level      = lvl_t'(m_tdata[10:9]);
        result_count++;
        if (alarm_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with nothing pending: slot %0d active %0d transition %0d level %0d",
                     $realtime, got.slot, got.active, got.transition, got.level);
        end else begin
          want = alarm_q.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch: expected slot %0d active %0d transition %0d level %0d,",
                        " got slot %0d active %0d transition %0d level %0d"},
                       $realtime, want.slot, want.active, want.transition, want.level,
                       got.slot, got.active, got.transition, got.level);
          end
        end
      end
    end
    pending = alarm_q.size();
  end

endmodule

// ----- tb/timed_hysteresis_alarm_qualifier_test.sv -----
module timed_hysteresis_alarm_qualifier_test;
  timeunit 1ns;
  timeprecision 1ps;
  import thaq_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 470;

  typedef enum int {
    ZONE_ASSERT,
    ZONE_RELEASE,
    ZONE_BAND,
    ZONE_ANY
  } sample_zone_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InDataW-1:0]   s_tdata = '0;
  logic [1:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutDataW-1:0]  m_tdata;

  int fail_count, pending, result_count, raise_count, clear_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_count = 0;
  int stall_cycles = 0;

  // Per-slot descriptor and sticky conditions for the random part.
  logic [1:0]   desc_kind     [64];
  logic         desc_latching [64];
  logic [15:0]  desc_limit    [64];
  logic [15:0]  desc_hyst     [64];
  logic [15:0]  desc_set      [64];
  logic [15:0]  desc_clear    [64];
  sample_zone_t slot_zone     [64];
  pre_t         slot_pre      [64];
  logic [31:0]  now_ms;

  timed_hysteresis_alarm_qualifier #(.ALARM_SLOTS(64)) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  timed_hysteresis_alarm_qualifier_checker #(.SLOTS(64)) checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .result_count(result_count),
    .raise_count (raise_count),
    .clear_count (clear_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("No transaction for %0d cycles, giving up.", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so back-to-back transactions need no second write.
  task automatic send_eval(input logic [5:0] slot, input logic [15:0] sample, input pre_t pre,
                           input logic [1:0] kind, input logic latching,
                           input logic [15:0] limit, input logic [15:0] hyst,
                           input logic [15:0] set_delay, input logic [15:0] clear_delay,
                           input logic [31:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, now, clear_delay, set_delay, hyst, limit, latching, pre, sample, slot};
    s_tuser  <= kind;
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    @(negedge clk);
    sent_count++;
  endtask

  function automatic pre_t pick_pre();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return PRE_NONE;
    if (r < 80) return PRE_RUNNING;
    if (r < 92) return PRE_FAULTED;
    return PRE_IDLE;
  endfunction

  function automatic void new_descriptor(int slot);
    int r;
    r = $urandom_range(0, 99);
    desc_kind[slot]     = (r < 4) ? KIND_UNUSED : 2'($urandom_range(0, 2));
    desc_latching[slot] = ($urandom_range(0, 99) < 25);
    r = $urandom_range(0, 99);
    desc_limit[slot] = (r < 4) ? 16'd0 : (r < 8) ? 16'hFFFF : 16'($urandom);
    desc_hyst[slot]  = ($urandom_range(0, 99) < 20) ? 16'($urandom) : 16'($urandom_range(0, 2000));
    desc_set[slot]   = ($urandom_range(0, 99) < 8) ? 16'($urandom) : 16'($urandom_range(0, 40));
    desc_clear[slot] = ($urandom_range(0, 99) < 8) ? 16'($urandom) : 16'($urandom_range(0, 40));
  endfunction

  function automatic logic [15:0] pick_sample(logic [1:0] kind, logic [15:0] limit,
                                              logic [15:0] hyst, sample_zone_t zone);
    int lim, hy, rel, top;
    lim = limit;
    hy  = hyst;
    pick_sample = 16'($urandom);
    case (kind)
      KIND_UPPER: begin
        rel = (lim > hy) ? lim - hy : 0;
        if (zone == ZONE_ASSERT) pick_sample = 16'($urandom_range(lim, 65535));
        else if (zone == ZONE_RELEASE) pick_sample = 16'($urandom_range(0, rel));
        else if (zone == ZONE_BAND && lim > rel + 1)
          pick_sample = 16'($urandom_range(rel + 1, lim - 1));
      end
      KIND_LOWER: begin
        top = (lim + hy > 65535) ? 65535 : lim + hy - 1;
        if (zone == ZONE_ASSERT) pick_sample = 16'($urandom_range(0, lim));
        else if (zone == ZONE_RELEASE && lim + hy <= 65535)
          pick_sample = 16'($urandom_range(lim + hy, 65535));
        else if (zone == ZONE_BAND && top > lim)
          pick_sample = 16'($urandom_range(lim + 1, top));
      end
      KIND_FLAG: begin
        if (zone == ZONE_ASSERT) pick_sample = 16'($urandom_range(1, 65535));
        else if (zone == ZONE_RELEASE) pick_sample = 16'd0;
      end
      default: ;
    endcase
  endfunction

  task automatic random_eval();
    int slot;
    if ($urandom_range(0, 99) < 6) begin
      // Noise: every field drawn freely, time included.
      send_eval(6'($urandom), 16'($urandom), pre_t'($urandom_range(0, 3)),
                2'($urandom_range(0, 3)), 1'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), $urandom);
      return;
    end
    slot = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 7) : $urandom_range(0, 63);
    if ($urandom_range(0, 99) < 3) new_descriptor(slot);
    if ($urandom_range(0, 99) < 15) slot_zone[slot] = sample_zone_t'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 10) slot_pre[slot] = pick_pre();
    now_ms += ($urandom_range(0, 99) < 2) ? $urandom_range(0, 70000) : $urandom_range(0, 6);
    send_eval(6'(slot),
              pick_sample(desc_kind[slot], desc_limit[slot], desc_hyst[slot], slot_zone[slot]),
              slot_pre[slot], desc_kind[slot], desc_latching[slot], desc_limit[slot],
              desc_hyst[slot], desc_set[slot], desc_clear[slot], now_ms);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Field extremes: all zeros, then all ones with the unused check kind.
    send_eval(6'd0, 16'd0, PRE_NONE, KIND_UPPER, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0);
    send_eval(6'd63, 16'hFFFF, PRE_FAULTED, KIND_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF,
              16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    // Upper limit: set delay must be strictly exceeded, equality edges on both sides.
    send_eval(6'd1, 16'd50, PRE_NONE, KIND_UPPER, 1'b0, 16'd100, 16'd10, 16'd5, 16'd3, 32'd1000);
    send_eval(6'd1, 16'd100, PRE_NONE, KIND_UPPER, 1'b0, 16'd100, 16'd10, 16'd5, 16'd3, 32'd1002);
    send_eval(6'd1, 16'hFFFF, PRE_NONE, KIND_UPPER, 1'b0, 16'd100, 16'd10, 16'd5, 16'd3, 32'd1005);
    send_eval(6'd1, 16'd100, PRE_NONE, KIND_UPPER, 1'b0, 16'd100, 16'd10, 16'd5, 16'd3, 32'd1006);
    send_eval(6'd1, 16'd90, PRE_FAULTED, KIND_UPPER, 1'b0, 16'd100, 16'd10, 16'd5, 16'd3, 32'd1007);
    send_eval(6'd1, 16'd95, PRE_NONE, KIND_UPPER, 1'b0, 16'd100, 16'd10, 16'd5, 16'd3, 32'd1009);
    send_eval(6'd1, 16'd90, PRE_NONE, KIND_UPPER, 1'b0, 16'd100, 16'd10, 16'd5, 16'd3, 32'd1010);
    send_eval(6'd1, 16'd0, PRE_NONE, KIND_UPPER, 1'b0, 16'd100, 16'd10, 16'd5, 16'd3, 32'd1014);
    // Release point clamped at zero when hysteresis exceeds the limit.
    send_eval(6'd2, 16'd0, PRE_NONE, KIND_UPPER, 1'b0, 16'd5, 16'hFFFF, 16'd0, 16'd0, 32'd1015);
    send_eval(6'd2, 16'd1, PRE_NONE, KIND_UPPER, 1'b0, 16'd5, 16'hFFFF, 16'd0, 16'd0, 32'd1015);
    // Lower limit, including a release point beyond the sample range.
    send_eval(6'd2, 16'd0, PRE_IDLE, KIND_LOWER, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd1016);
    send_eval(6'd2, 16'hFFFF, PRE_FAULTED, KIND_LOWER, 1'b0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0,
              32'd1017);
    send_eval(6'd2, 16'hFFFF, PRE_NONE, KIND_LOWER, 1'b0, 16'd100, 16'hFFFF, 16'd9, 16'd0, 32'd1018);
    send_eval(6'd2, 16'd120, PRE_NONE, KIND_LOWER, 1'b0, 16'd100, 16'd20, 16'd9, 16'd0, 32'd1019);
    // Latching flag alarm holds through release until the precondition goes idle.
    send_eval(6'd3, 16'h8000, PRE_RUNNING, KIND_FLAG, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 32'd1020);
    send_eval(6'd3, 16'd0, PRE_NONE, KIND_FLAG, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 32'd1100);
    send_eval(6'd3, 16'd0, PRE_RUNNING, KIND_FLAG, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 32'd1101);
    send_eval(6'd3, 16'd1, PRE_IDLE, KIND_FLAG, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 32'd1102);
    // Qualification across the 32-bit time wrap, then an idle precondition clear.
    send_eval(6'd4, 16'd0, PRE_NONE, KIND_UPPER, 1'b0, 16'd1000, 16'd100, 16'd16, 16'hFFFF,
              32'hFFFF_FFF0);
    send_eval(6'd4, 16'd2000, PRE_NONE, KIND_UPPER, 1'b0, 16'd1000, 16'd100, 16'd16, 16'hFFFF,
              32'hFFFF_FFF8);
    send_eval(6'd4, 16'd2000, PRE_NONE, KIND_UPPER, 1'b0, 16'd1000, 16'd100, 16'd16, 16'hFFFF,
              32'd1);
    send_eval(6'd4, 16'd900, PRE_NONE, KIND_UPPER, 1'b0, 16'd1000, 16'd100, 16'd16, 16'hFFFF,
              32'd5);
    send_eval(6'd4, 16'd900, PRE_IDLE, KIND_UPPER, 1'b0, 16'd1000, 16'd100, 16'd16, 16'hFFFF,
              32'd6);

    for (int i = 0; i < 64; i++) begin
      new_descriptor(i);
      slot_zone[i] = sample_zone_t'($urandom_range(0, 3));
      slot_pre[i]  = pick_pre();
    end
    // Start close to the top of the time range so the random part wraps too.
    now_ms = 32'hFFFF_FFFF - $urandom_range(1000, 3000);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 77 : 0;
      recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 34 : 0;
      repeat (PHASE_ITEMS) random_eval();
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Ran %0d alarm evaluations: directed edge cases, then random slot histories",
             sent_count);
    $display("under three idling mixes; %0d results checked, %0d raises and %0d clears seen.",
             result_count, raise_count, clear_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
